// File: rtl/tdml_pkg.sv
// Shared constants, types and arithmetic helpers of the max-log-MAP turbo decoder.
package tdml_pkg;

    localparam int MAX_BLOCK = 1024;
    localparam int SOFT_W    = 8;
    localparam int MW        = 24;
    localparam int EXT_W     = 16;
    localparam int NSTATE    = 8;
    localparam int ADDR_W    = $clog2(MAX_BLOCK);
    localparam int LEN_W     = 11;
    localparam int ITER_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int X_W       = SOFT_W + 1;
    localparam int B1_W      = X_W + 8;
    localparam int B2_W      = X_W + 3;
    localparam int SUM_W     = MW + 3;
    localparam int EXT_SUM_W = MW + 4;
    localparam int WORD_W    = 64;
    localparam int WBIT_W    = $clog2(WORD_W);
    localparam int WNUM_W    = 4;
    localparam int BETA_ROWS = MAX_BLOCK + 3;
    localparam int ROW_W     = $clog2(BETA_ROWS);
    localparam int PH_W      = 3;
    localparam int NTAIL     = 3;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(696);
    localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(5);

    localparam logic signed [MW-1:0] MIN_METRIC   = MW'(-100000);
    localparam logic signed [MW-1:0] FLOOR_METRIC = {1'b1, {(MW-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] MET_HI = SUM_W'((2**(MW-1)) - 1);
    localparam logic signed [SUM_W-1:0] MET_LO = SUM_W'(-(2**(MW-1)));
    localparam logic signed [EXT_SUM_W-1:0] EXT_HI = EXT_SUM_W'((2**(EXT_W-1)) - 1);
    localparam logic signed [EXT_SUM_W-1:0] EXT_LO = EXT_SUM_W'(-(2**(EXT_W-1)));

    // Last phase of one position in each sequencer state.
    localparam logic [PH_W-1:0] PH_CLEAR_END   = PH_W'(0);
    localparam logic [PH_W-1:0] PH_BACK_END    = PH_W'(3);
    localparam logic [PH_W-1:0] PH_FWD_END     = PH_W'(5);
    localparam logic [PH_W-1:0] PH_GATHER_END  = PH_W'(2);
    localparam logic [PH_W-1:0] PH_SCATTER_END = PH_W'(1);
    localparam logic [PH_W-1:0] PH_OUT_END     = PH_W'(1);

    // Trellis of the constituent encoder: next state and parity per state and input bit.
    localparam logic [2:0] NEXT_ST [NSTATE][2] = '{
        '{3'd0, 3'd4}, '{3'd4, 3'd0}, '{3'd5, 3'd1}, '{3'd1, 3'd5},
        '{3'd2, 3'd6}, '{3'd6, 3'd2}, '{3'd7, 3'd3}, '{3'd3, 3'd7}};
    localparam logic PAR_BIT [NSTATE][2] = '{
        '{1'b0, 1'b1}, '{1'b0, 1'b1}, '{1'b1, 1'b0}, '{1'b1, 1'b0},
        '{1'b1, 1'b0}, '{1'b1, 1'b0}, '{1'b0, 1'b1}, '{1'b0, 1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_BACK, ST_FWD, ST_GATHER, ST_SCATTER, ST_OUT, ST_SHOW
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_LENGTH    = 2'd0,
        CFG_ITERATION_COUNT = 2'd1
    } t_cfg_index;

    typedef logic signed [MW-1:0] t_metric;

    function automatic logic signed [SUM_W-1:0] gamma_f(
        input logic signed [B1_W-1:0] b1, input logic signed [B2_W-1:0] b2,
        input logic u, input logic p);
        logic signed [SUM_W-1:0] e1;
        logic signed [SUM_W-1:0] e2;
        e1 = SUM_W'(b1);
        e2 = SUM_W'(b2);
        return (u ? e1 : -e1) + (p ? e2 : -e2);
    endfunction

    function automatic t_metric sat_metric(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = (v > MET_HI) ? MET_HI : ((v < MET_LO) ? MET_LO : v);
        return r[MW-1:0];
    endfunction

    function automatic logic signed [EXT_W-1:0] sat_ext(input logic signed [EXT_SUM_W-1:0] v);
        logic signed [EXT_SUM_W-1:0] r;
        r = (v > EXT_HI) ? EXT_HI : ((v < EXT_LO) ? EXT_LO : v);
        return r[EXT_W-1:0];
    endfunction

endpackage

// File: rtl/turbo_decoder_max_log_map.sv
// Top level of the max-log-MAP turbo decoder: stores, trellis sequencer and output packer.
//
// A code block is loaded one data position per input beat (systematic, parity one, parity
// two and interleaver entry) into single-port block memories, followed by three tail beats;
// the third tail beat starts decoding, and input stays stalled until the last decision word
// has been taken. Every trellis step is a short read-modify-write sequence around the
// memories: the backward pass stores all eight state metrics of a step as one 192-bit row,
// and each forward step runs through read, branch metrics, add-compare, maximum search and
// extrinsic write in turn; the interleaver exchange steps through every position. At decode
// start a pass clears the a-priori and decision stores. Configuration writes are always
// accepted and must only be issued while idle.
module turbo_decoder_max_log_map (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_kind,
    input  logic signed [tdml_pkg::SOFT_W-1:0]   i_value_a,
    input  logic signed [tdml_pkg::SOFT_W-1:0]   i_value_b,
    input  logic signed [tdml_pkg::SOFT_W-1:0]   i_value_c,
    input  logic signed [tdml_pkg::SOFT_W-1:0]   i_value_d,
    input  logic [tdml_pkg::ADDR_W-1:0]          i_perm_index,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [tdml_pkg::WORD_W-1:0]          o_decided_bits,
    output logic [tdml_pkg::WNUM_W-1:0]          o_word_number,
    output logic                                 o_last_word,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tdml_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tdml_pkg::LEN_W-1:0]           i_cfg_data
);
    import tdml_pkg::*;

    // Block memories. Reads are registered and enabled only in the phase that needs them.
    logic signed [SOFT_W-1:0] m_sys  [MAX_BLOCK];
    logic signed [SOFT_W-1:0] m_par1 [MAX_BLOCK];
    logic signed [SOFT_W-1:0] m_par2 [MAX_BLOCK];
    logic [ADDR_W-1:0]        m_perm [MAX_BLOCK];
    logic signed [EXT_W-1:0]  m_ext  [MAX_BLOCK];
    logic signed [EXT_W-1:0]  m_apr  [MAX_BLOCK];
    logic                     m_dec  [MAX_BLOCK];
    logic [NSTATE*MW-1:0]     m_beta [BETA_ROWS];

    // Tail values, one entry per tail beat.
    logic signed [SOFT_W-1:0] r_tail_a [NTAIL];
    logic signed [SOFT_W-1:0] r_tail_b [NTAIL];
    logic signed [SOFT_W-1:0] r_tail_c [NTAIL];
    logic signed [SOFT_W-1:0] r_tail_d [NTAIL];

    // Control state.
    t_state              r_state, n_state;
    logic [PH_W-1:0]     r_ph;
    logic [ROW_W-1:0]    r_t;
    logic                r_half;
    logic [ITER_W-1:0]   r_iter, r_iters;
    logic [LEN_W-1:0]    r_n;
    logic [LEN_W-1:0]    r_block_length;
    logic [ITER_W-1:0]   r_iteration_count;
    logic [LEN_W-1:0]    r_load_pos;
    logic [1:0]          r_tail_cnt;
    logic                r_out_valid;

    // Datapath registers.
    t_metric                  r_alpha [NSTATE];
    t_metric                  r_beta  [NSTATE];
    t_metric                  r_c0    [NSTATE];
    t_metric                  r_c1    [NSTATE];
    t_metric                  r_mx0, r_mx1;
    logic signed [B1_W-1:0]   r_b1;
    logic signed [B2_W-1:0]   r_b2;
    logic signed [X_W-1:0]    r_x;
    logic signed [EXT_W-1:0]  r_apr;
    logic [ADDR_W-1:0]        r_eff;
    logic [WORD_W-1:0]        r_bits;
    logic [WNUM_W-1:0]        r_wnum;
    logic                     r_last;

    // Memory read data registers.
    logic signed [SOFT_W-1:0] r_sys_rd, r_par1_rd, r_par2_rd;
    logic [ADDR_W-1:0]        r_perm_rd;
    logic signed [EXT_W-1:0]  r_ext_rd, r_apr_rd;
    logic                     r_dec_rd;
    logic [NSTATE*MW-1:0]     r_beta_rd;

    // Handshakes and derived control.
    logic              in_acc, load_we, tail_start, step_done, last_pos, last_iter;
    logic [PH_W-1:0]   ph_end;
    logic [ADDR_W-1:0] t_addr, eff_c;
    logic [LEN_W-1:0]  n_eff;
    logic [ITER_W-1:0] iters_eff;

    // Memory controls driven by the sequencer.
    logic              sys_re, par_re, perm_re, apr_re, ext_re, dec_re, beta_re;
    logic [ADDR_W-1:0] sys_raddr, ext_raddr, apr_waddr, dec_waddr;
    logic              apr_we, ext_we, dec_we, beta_we;
    logic signed [EXT_W-1:0] apr_wdata;
    logic              dec_wdata;

    // Arithmetic.
    t_metric                  beta_new  [NSTATE];
    t_metric                  beta_nx   [NSTATE];
    t_metric                  alpha_nxt [NSTATE];
    t_metric                  fc0 [NSTATE];
    t_metric                  fc1 [NSTATE];
    t_metric                  mx0_c, mx1_c;
    logic signed [B1_W-1:0]   b1_c;
    logic signed [B2_W-1:0]   b2_c;
    logic signed [X_W-1:0]    x_c;
    logic signed [EXT_W-1:0]  ext_c;
    logic [NSTATE*MW-1:0]     beta_row;
    logic [LEN_W-1:0]         word_end;

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_decided_bits = r_bits;
    assign o_word_number  = r_wnum;
    assign o_last_word    = r_last;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign load_we    = in_acc && !i_kind && (r_load_pos < r_block_length) &&
                        (r_load_pos < LEN_W'(MAX_BLOCK));
    assign tail_start = in_acc && i_kind && (r_tail_cnt == 2'd2);
    assign t_addr     = r_t[ADDR_W-1:0];
    assign last_pos   = (r_t == r_n - LEN_W'(1));
    assign last_iter  = (r_iter == r_iters - ITER_W'(1));
    // Interleaver entries outside the block fall back to the position itself.
    assign eff_c      = ({1'b0, r_perm_rd} < r_n) ? r_perm_rd : t_addr;
    assign n_eff      = (r_block_length == '0) ? LEN_W'(1) :
                        ((r_block_length > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK) : r_block_length);
    assign iters_eff  = (r_iteration_count == '0) ? ITER_W'(1) : r_iteration_count;
    assign word_end   = {1'b0, r_t[ADDR_W-1:WBIT_W], {WBIT_W{1'b0}}} + LEN_W'(WORD_W);

    // Last phase of the current position.
    always_comb begin
        case (r_state)
            ST_CLEAR:   ph_end = PH_CLEAR_END;
            ST_BACK:    ph_end = PH_BACK_END;
            ST_FWD:     ph_end = PH_FWD_END;
            ST_GATHER:  ph_end = PH_GATHER_END;
            ST_SCATTER: ph_end = PH_SCATTER_END;
            ST_OUT:     ph_end = PH_OUT_END;
            default:    ph_end = '0;
        endcase
    end
    assign step_done = (r_ph == ph_end);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (tail_start) n_state = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (step_done && last_pos) n_state = ST_BACK;
            end
            ST_BACK: begin
                if (step_done && r_t == '0) n_state = ST_FWD;
            end
            ST_FWD: begin
                if (step_done && last_pos) begin
                    if (!r_half)        n_state = ST_GATHER;
                    else if (last_iter) n_state = ST_OUT;
                    else                n_state = ST_SCATTER;
                end
            end
            ST_GATHER, ST_SCATTER: begin
                if (step_done && last_pos) n_state = ST_BACK;
            end
            ST_OUT: begin
                if (step_done && r_t[WBIT_W-1:0] == '1) n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (!i_out_stall) n_state = r_last ? ST_IDLE : ST_OUT;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory controls per state and phase.
    always_comb begin
        sys_re    = 1'b0;
        par_re    = 1'b0;
        perm_re   = 1'b0;
        apr_re    = 1'b0;
        ext_re    = 1'b0;
        dec_re    = 1'b0;
        beta_re   = 1'b0;
        apr_we    = 1'b0;
        ext_we    = 1'b0;
        dec_we    = 1'b0;
        beta_we   = 1'b0;
        sys_raddr = t_addr;
        ext_raddr = t_addr;
        apr_waddr = t_addr;
        apr_wdata = '0;
        dec_waddr = t_addr;
        dec_wdata = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                apr_we = 1'b1;
                dec_we = 1'b1;
            end
            ST_BACK, ST_FWD: begin
                if (r_ph == PH_W'(0)) begin
                    perm_re = 1'b1;
                    par_re  = 1'b1;
                    apr_re  = 1'b1;
                    beta_re = (r_state == ST_FWD);
                end
                if (r_ph == PH_W'(1)) begin
                    sys_re    = 1'b1;
                    sys_raddr = r_half ? eff_c : t_addr;
                end
                if (r_state == ST_BACK && r_ph == PH_BACK_END) beta_we = 1'b1;
                if (r_state == ST_FWD && r_ph == PH_FWD_END) begin
                    ext_we    = 1'b1;
                    dec_we    = r_half && last_iter;
                    dec_waddr = r_eff;
                    dec_wdata = (r_mx1 > r_mx0);
                end
            end
            ST_SCATTER: begin
                if (r_ph == PH_W'(0)) begin
                    ext_re  = 1'b1;
                    perm_re = 1'b1;
                end else begin
                    apr_we    = 1'b1;
                    apr_waddr = eff_c;
                    apr_wdata = r_ext_rd;
                end
            end
            ST_GATHER: begin
                if (r_ph == PH_W'(0)) perm_re = 1'b1;
                if (r_ph == PH_W'(1)) begin
                    ext_re    = 1'b1;
                    ext_raddr = eff_c;
                end
                if (r_ph == PH_GATHER_END) begin
                    apr_we    = 1'b1;
                    apr_wdata = r_ext_rd;
                end
            end
            ST_OUT: begin
                if (r_ph == PH_W'(0)) dec_re = 1'b1;
            end
            default: ;
        endcase
    end

    // Branch metrics of the current step; tail steps take their values from the tail entries.
    always_comb begin
        logic                     is_tail;
        logic [LEN_W-1:0]         tk_full;
        logic [1:0]               tk;
        logic signed [SOFT_W-1:0] xr, yr;
        logic signed [X_W-1:0]    y9;
        logic signed [B1_W-1:0]   x16;
        is_tail = (r_t >= r_n);
        tk_full = r_t - r_n;
        tk      = tk_full[1:0];
        if (is_tail) begin
            xr = r_half ? r_tail_c[tk] : r_tail_a[tk];
            yr = r_half ? r_tail_d[tk] : r_tail_b[tk];
        end else begin
            xr = r_sys_rd;
            yr = r_half ? r_par2_rd : r_par1_rd;
        end
        x_c  = -X_W'(xr);
        y9   = -X_W'(yr);
        x16  = B1_W'($signed({x_c, 4'b0}));
        b2_c = $signed({y9, 3'b0});
        if (is_tail) b1_c = B1_W'($signed({x_c, 3'b0}));
        else         b1_c = (x16 + B1_W'(r_apr_rd)) >>> 1;
    end

    // Backward add-compare-select over the eight states.
    always_comb begin
        t_metric c0, c1;
        for (int s = 0; s < NSTATE; s++) begin
            c0 = sat_metric(gamma_f(r_b1, r_b2, 1'b0, PAR_BIT[s][0]) +
                            SUM_W'(r_beta[NEXT_ST[s][0]]));
            c1 = sat_metric(gamma_f(r_b1, r_b2, 1'b1, PAR_BIT[s][1]) +
                            SUM_W'(r_beta[NEXT_ST[s][1]]));
            beta_new[s] = (c1 > c0) ? c1 : c0;
            beta_row[s*MW +: MW] = beta_new[s];
        end
    end

    // Forward step: new state metrics and the path sums for both input bits.
    always_comb begin
        logic signed [SUM_W-1:0] g0, g1;
        t_metric a0, a1;
        for (int s = 0; s < NSTATE; s++) begin
            beta_nx[s]   = r_beta_rd[s*MW +: MW];
            alpha_nxt[s] = FLOOR_METRIC;
        end
        for (int s = 0; s < NSTATE; s++) begin
            g0 = gamma_f(r_b1, r_b2, 1'b0, PAR_BIT[s][0]);
            g1 = gamma_f(r_b1, r_b2, 1'b1, PAR_BIT[s][1]);
            a0 = sat_metric(SUM_W'(r_alpha[s]) + g0);
            a1 = sat_metric(SUM_W'(r_alpha[s]) + g1);
            fc0[s] = sat_metric(SUM_W'(r_alpha[s]) + g0 + SUM_W'(beta_nx[NEXT_ST[s][0]]));
            fc1[s] = sat_metric(SUM_W'(r_alpha[s]) + g1 + SUM_W'(beta_nx[NEXT_ST[s][1]]));
            if (a0 > alpha_nxt[NEXT_ST[s][0]]) alpha_nxt[NEXT_ST[s][0]] = a0;
            if (a1 > alpha_nxt[NEXT_ST[s][1]]) alpha_nxt[NEXT_ST[s][1]] = a1;
        end
    end

    // Maximum over the registered path sums, and the extrinsic value.
    always_comb begin
        logic signed [EXT_SUM_W-1:0] es;
        mx0_c = FLOOR_METRIC;
        mx1_c = FLOOR_METRIC;
        for (int s = 0; s < NSTATE; s++) begin
            if (r_c0[s] > mx0_c) mx0_c = r_c0[s];
            if (r_c1[s] > mx1_c) mx1_c = r_c1[s];
        end
        es = EXT_SUM_W'(r_mx1) - EXT_SUM_W'(r_mx0) - EXT_SUM_W'($signed({r_x, 4'b0})) -
             EXT_SUM_W'(r_apr);
        ext_c = sat_ext(es);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length    <= LEN_RESET;
            r_iteration_count <= ITER_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BLOCK_LENGTH:    r_block_length    <= i_cfg_data;
                CFG_ITERATION_COUNT: r_iteration_count <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= '0;
            r_t         <= '0;
            r_half      <= 1'b0;
            r_iter      <= '0;
            r_iters     <= ITER_W'(1);
            r_n         <= LEN_W'(1);
            r_load_pos  <= '0;
            r_tail_cnt  <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NSTATE; s++) r_alpha[s] <= (s == 0) ? '0 : MIN_METRIC;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                if (load_we) r_load_pos <= r_load_pos + LEN_W'(1);
                if (in_acc && i_kind) begin
                    if (tail_start) begin
                        r_tail_cnt <= '0;
                        r_load_pos <= '0;
                        r_t        <= '0;
                        r_ph       <= '0;
                        r_n        <= n_eff;
                        r_iters    <= iters_eff;
                        r_iter     <= '0;
                        r_half     <= 1'b0;
                    end else begin
                        r_tail_cnt <= r_tail_cnt + 2'd1;
                    end
                end
            end else if (r_state == ST_SHOW) begin
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                    r_t         <= r_t + ROW_W'(1);
                end
            end else if (!step_done) begin
                r_ph <= r_ph + PH_W'(1);
            end else begin
                r_ph <= '0;
                case (r_state)
                    ST_CLEAR, ST_GATHER, ST_SCATTER: begin
                        r_t <= last_pos ? r_n + ROW_W'(2) : r_t + ROW_W'(1);
                    end
                    ST_BACK: begin
                        if (r_t != '0) r_t <= r_t - ROW_W'(1);
                    end
                    ST_FWD: begin
                        if (last_pos) begin
                            r_t <= '0;
                            if (!r_half) begin
                                r_half <= 1'b1;
                            end else if (!last_iter) begin
                                r_half <= 1'b0;
                                r_iter <= r_iter + ITER_W'(1);
                            end
                        end else begin
                            r_t <= r_t + ROW_W'(1);
                        end
                    end
                    ST_OUT: begin
                        if (r_t[WBIT_W-1:0] == '1) r_out_valid <= 1'b1;
                        else                       r_t <= r_t + ROW_W'(1);
                    end
                    default: ;
                endcase
            end
            // Alpha starts from the known state at the head of each forward pass.
            if (n_state == ST_FWD && r_state != ST_FWD) begin
                for (int s = 0; s < NSTATE; s++) r_alpha[s] <= (s == 0) ? '0 : MIN_METRIC;
            end else if (r_state == ST_FWD && r_ph == PH_W'(3)) begin
                for (int s = 0; s < NSTATE; s++) r_alpha[s] <= alpha_nxt[s];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (n_state == ST_BACK && r_state != ST_BACK) begin
            for (int s = 0; s < NSTATE; s++) r_beta[s] <= (s == 0) ? '0 : MIN_METRIC;
        end else if (r_state == ST_BACK && r_ph == PH_BACK_END) begin
            for (int s = 0; s < NSTATE; s++) r_beta[s] <= beta_new[s];
        end
        if ((r_state == ST_BACK || r_state == ST_FWD) && r_ph == PH_W'(1)) r_eff <= eff_c;
        if ((r_state == ST_BACK || r_state == ST_FWD) && r_ph == PH_W'(2)) begin
            r_b1  <= b1_c;
            r_b2  <= b2_c;
            r_x   <= x_c;
            r_apr <= r_apr_rd;
        end
        if (r_state == ST_FWD && r_ph == PH_W'(3)) begin
            for (int s = 0; s < NSTATE; s++) begin
                r_c0[s] <= fc0[s];
                r_c1[s] <= fc1[s];
            end
        end
        if (r_state == ST_FWD && r_ph == PH_W'(4)) begin
            r_mx0 <= mx0_c;
            r_mx1 <= mx1_c;
        end
        if (r_state == ST_OUT && r_ph == PH_OUT_END) begin
            r_bits[r_t[WBIT_W-1:0]] <= r_dec_rd && (r_t < r_n);
            r_wnum <= r_t[ADDR_W-1:WBIT_W];
            r_last <= (word_end >= r_n);
        end
        if (in_acc && i_kind) begin
            r_tail_a[r_tail_cnt] <= i_value_a;
            r_tail_b[r_tail_cnt] <= i_value_b;
            r_tail_c[r_tail_cnt] <= i_value_c;
            r_tail_d[r_tail_cnt] <= i_value_d;
        end
    end

    // Block memories.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            m_sys[r_load_pos[ADDR_W-1:0]]  <= i_value_a;
            m_par1[r_load_pos[ADDR_W-1:0]] <= i_value_b;
            m_par2[r_load_pos[ADDR_W-1:0]] <= i_value_c;
            m_perm[r_load_pos[ADDR_W-1:0]] <= i_perm_index;
        end
        if (sys_re)  r_sys_rd  <= m_sys[sys_raddr];
        if (par_re) begin
            r_par1_rd <= m_par1[t_addr];
            r_par2_rd <= m_par2[t_addr];
        end
        if (perm_re) r_perm_rd <= m_perm[t_addr];
    end

    always_ff @(posedge i_clk) begin
        if (apr_we) m_apr[apr_waddr] <= apr_wdata;
        if (apr_re) r_apr_rd <= m_apr[t_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ext_we) m_ext[t_addr] <= ext_c;
        if (ext_re) r_ext_rd <= m_ext[ext_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dec_we) m_dec[dec_waddr] <= dec_wdata;
        if (dec_re) r_dec_rd <= m_dec[t_addr];
    end

    always_ff @(posedge i_clk) begin
        if (beta_we) m_beta[r_t] <= beta_row;
        if (beta_re) r_beta_rd <= m_beta[r_t + ROW_W'(1)];
    end

endmodule

// File: rtl/tdml_checker.sv
// Port-level checker for the turbo decoder, bound to the top level.
module tdml_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [tdml_pkg::WORD_W-1:0]   o_decided_bits,
    input logic [tdml_pkg::WNUM_W-1:0]   o_word_number,
    input logic                          o_last_word
);
    import tdml_pkg::*;

    // A decision word is only shown while the decoder holds off new input.
    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("decision word shown while input is open");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_decided_bits) &&
            $stable(o_word_number) && $stable(o_last_word)))
        else $error("stalled decision word changed");

    // Each word is gathered bit by bit, so a taken word is never followed at once.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("decision word repeated without gathering");

    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=> !o_in_stall)
        else $error("input not reopened after the last word");

endmodule

bind turbo_decoder_max_log_map tdml_checker u_tdml_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench of the max-log-MAP turbo decoder with its own bit-exact predictor.

class decode_scoreboard;

    typedef struct {
        logic [63:0] bits;
        logic [3:0]  num;
        logic        last;
    } t_decision_word;

    t_decision_word words_due[$];
    int             errors;

    // Register copies and the block stores, as the decoder keeps them.
    int unsigned block_len;
    int unsigned iter_cnt;
    int          sys_mem[1024];
    int          par1_mem[1024];
    int          par2_mem[1024];
    int unsigned perm_mem[1024];
    int          tail_mem[12];
    int unsigned load_pos;
    int unsigned tail_cnt;
    int unsigned high_water;

    int          extr[1024];
    int          apri[1024];
    longint      beta_m[1028][8];
    longint      alpha_m[8];
    longint      llr[1024];
    int unsigned eperm[1024];
    int          x1[1027], y1[1027], x2[1027], y2[1027];
    bit          dec_bits[1024];

    function new();
        block_len  = 696;
        iter_cnt   = 5;
        load_pos   = 0;
        tail_cnt   = 0;
        high_water = 0;
        errors     = 0;
    endfunction

    function void configure(tdml_pkg::t_cfg_index idx, int unsigned value);
        if (idx == tdml_pkg::CFG_BLOCK_LENGTH) begin
            block_len = value & 11'h7FF;
        end else begin
            iter_cnt = value & 4'hF;
        end
    endfunction

    function longint sat(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint branch(longint b1, longint b2, bit u, bit p);
        return (u ? b1 : -b1) + (p ? b2 : -b2);
    endfunction

    // One constituent decoder: backward pass, then forward pass with LLR and extrinsic.
    function void constituent(bit second, int unsigned n);
        longint floor_m;
        longint minm;
        longint b1, b2, best, c, a, g;
        longint mx[2];
        longint nxt[8];
        int     xv, yv, ns;
        floor_m = sat(-(longint'(1) <<< 62), tdml_pkg::MW);
        minm    = sat(-100000, tdml_pkg::MW);
        for (int s = 0; s < 8; s++) beta_m[n + 3][s] = s ? minm : 0;
        for (int t = n + 2; t >= 0; t--) begin
            xv = second ? x2[t] : x1[t];
            yv = second ? y2[t] : y1[t];
            b1 = (t < n) ? ((longint'(xv) * 16 + apri[t]) >>> 1) : longint'(xv) * 8;
            b2 = longint'(yv) * 8;
            for (int s = 0; s < 8; s++) begin
                best = floor_m;
                for (int u = 0; u < 2; u++) begin
                    c = sat(branch(b1, b2, u, tdml_pkg::PAR_BIT[s][u]) +
                            beta_m[t + 1][tdml_pkg::NEXT_ST[s][u]], tdml_pkg::MW);
                    if (c > best) best = c;
                end
                beta_m[t][s] = best;
            end
        end
        for (int s = 0; s < 8; s++) alpha_m[s] = s ? minm : 0;
        for (int t = 0; t < n; t++) begin
            xv = second ? x2[t] : x1[t];
            yv = second ? y2[t] : y1[t];
            b1 = (longint'(xv) * 16 + apri[t]) >>> 1;
            b2 = longint'(yv) * 8;
            mx[0] = floor_m;
            mx[1] = floor_m;
            for (int s = 0; s < 8; s++) nxt[s] = floor_m;
            for (int s = 0; s < 8; s++) begin
                for (int u = 0; u < 2; u++) begin
                    ns = tdml_pkg::NEXT_ST[s][u];
                    g  = branch(b1, b2, u, tdml_pkg::PAR_BIT[s][u]);
                    c  = sat(alpha_m[s] + g + beta_m[t + 1][ns], tdml_pkg::MW);
                    a  = sat(alpha_m[s] + g, tdml_pkg::MW);
                    if (c > mx[u]) mx[u] = c;
                    if (a > nxt[ns]) nxt[ns] = a;
                end
            end
            llr[t]  = mx[1] - mx[0];
            extr[t] = int'(sat(llr[t] - longint'(xv) * 16 - apri[t], 16));
            for (int s = 0; s < 8; s++) alpha_m[s] = nxt[s];
        end
    endfunction

    function void decode_block();
        int unsigned n, iters, nwords;
        t_decision_word dw;
        n     = block_len;
        iters = iter_cnt;
        if (n == 0) n = 1;
        if (n > 1024) n = 1024;
        if (iters == 0) iters = 1;
        for (int k = 0; k < n; k++) eperm[k] = (perm_mem[k] < n) ? perm_mem[k] : k;
        for (int k = 0; k < n; k++) begin
            x1[k] = -sys_mem[k];
            y1[k] = -par1_mem[k];
            x2[k] = -sys_mem[eperm[k]];
            y2[k] = -par2_mem[k];
        end
        for (int k = 0; k < 3; k++) begin
            x1[n + k] = -tail_mem[4 * k];
            y1[n + k] = -tail_mem[4 * k + 1];
            x2[n + k] = -tail_mem[4 * k + 2];
            y2[n + k] = -tail_mem[4 * k + 3];
        end
        for (int k = 0; k < 1024; k++) begin
            extr[k]     = 0;
            apri[k]     = 0;
            dec_bits[k] = 0;
        end
        for (int it = 0; it < iters; it++) begin
            for (int k = 0; k < n; k++) apri[eperm[k]] = extr[k];
            constituent(0, n);
            for (int k = 0; k < n; k++) apri[k] = extr[eperm[k]];
            constituent(1, n);
        end
        for (int k = 0; k < n; k++) dec_bits[eperm[k]] = llr[k] > 0;
        nwords = (n + 63) / 64;
        for (int w = 0; w < nwords; w++) begin
            dw.bits = '0;
            for (int k = 0; k < 64 && w * 64 + k < n; k++) dw.bits[k] = dec_bits[w * 64 + k];
            dw.num  = w[3:0];
            dw.last = (w + 1 == nwords);
            words_due.push_back(dw);
        end
    endfunction

    // Notes an accepted input beat and queues the decision words it causes.
    function void note_input(bit kind, int a, int b, int c, int d, int unsigned perm);
        if (!kind) begin
            if (load_pos < block_len && load_pos < 1024) begin
                sys_mem[load_pos]  = a;
                par1_mem[load_pos] = b;
                par2_mem[load_pos] = c;
                perm_mem[load_pos] = perm;
                load_pos++;
                if (load_pos > high_water) high_water = load_pos;
            end
            return;
        end
        if (tail_cnt > 2) tail_cnt = 0;
        tail_mem[4 * tail_cnt]     = a;
        tail_mem[4 * tail_cnt + 1] = b;
        tail_mem[4 * tail_cnt + 2] = c;
        tail_mem[4 * tail_cnt + 3] = d;
        tail_cnt++;
        if (tail_cnt < 3) return;
        tail_cnt = 0;
        load_pos = 0;
        decode_block();
    endfunction

    // Compares one accepted decision word with the oldest one due.
    function void check_word(logic [63:0] bits, logic [3:0] num, logic last);
        t_decision_word dw;
        if (words_due.size() == 0) begin
            $display("%0t: unexpected decision word, bits %h word %0d last %0b",
                     $time, bits, num, last);
            errors++;
            return;
        end
        dw = words_due.pop_front();
        if (bits !== dw.bits) begin
            $display("%0t: decided_bits expected %h actual %h", $time, dw.bits, bits);
            errors++;
        end
        if (num !== dw.num) begin
            $display("%0t: word_number expected %0d actual %0d", $time, dw.num, num);
            errors++;
        end
        if (last !== dw.last) begin
            $display("%0t: last_word expected %0b actual %0b", $time, dw.last, last);
            errors++;
        end
    endfunction

endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tdml_pkg::*;

    // No beat of any kind for this many cycles means the decoder hung.
    localparam int IDLE_LIMIT = 400000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_kind = 1'b0;
    logic signed [SOFT_W-1:0] i_value_a = '0;
    logic signed [SOFT_W-1:0] i_value_b = '0;
    logic signed [SOFT_W-1:0] i_value_c = '0;
    logic signed [SOFT_W-1:0] i_value_d = '0;
    logic [ADDR_W-1:0]        i_perm_index = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [WORD_W-1:0]        o_decided_bits;
    logic [WNUM_W-1:0]        o_word_number;
    logic                     o_last_word;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [LEN_W-1:0]         i_cfg_data = '0;

    decode_scoreboard sb = new();

    // Idle percentages of the sender and the receiver in the current phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned perm_order[1024];

    always #10 i_clk = ~i_clk;

    turbo_decoder_max_log_map u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_value_a      (i_value_a),
        .i_value_b      (i_value_b),
        .i_value_c      (i_value_c),
        .i_value_d      (i_value_d),
        .i_perm_index   (i_perm_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_decided_bits (o_decided_bits),
        .o_word_number  (o_word_number),
        .o_last_word    (o_last_word),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every decision word that is taken is checked against the oldest one due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_word(o_decided_bits, o_word_number, o_last_word);
        end
    end

    // The watchdog restarts on any beat on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Waits until every decision word has come, then lets the decoder settle before a
    // register write.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.words_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[LEN_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.configure(idx, value);
    endtask

    task automatic set_mode(int unsigned mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    // Sends one beat, with a random gap in front of it at the sender's idle rate.
    task automatic send_beat(bit kind, int a, int b, int c, int d, int unsigned perm);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_value_a    <= a[7:0];
        i_value_b    <= b[7:0];
        i_value_c    <= c[7:0];
        i_value_d    <= d[7:0];
        i_perm_index <= perm[9:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(kind, a, b, c, d, perm);
        items_sent++;
    endtask

    function automatic int soft_value();
        case ($urandom_range(9))
            0: return -128;
            1: return 127;
            2: return $urandom_range(8) - 4;
            default: return int'($urandom_range(255)) - 128;
        endcase
    endfunction

    // Sends data beats of one block and its three tail beats. Interleaver entries mostly
    // form a true permutation of the block; some are out of range or repeated.
    task automatic send_block(int unsigned n_data, int unsigned n_len);
        int unsigned tmp, j, perm;
        for (int k = 0; k < n_len && k < 1024; k++) perm_order[k] = k;
        for (int k = n_len - 1; k > 0 && k < 1024; k--) begin
            j = $urandom_range(k);
            tmp = perm_order[k];
            perm_order[k] = perm_order[j];
            perm_order[j] = tmp;
        end
        for (int k = 0; k < n_data; k++) begin
            case ($urandom_range(9))
                0: perm = $urandom_range(1023);
                1: perm = (k > 0) ? perm_order[0] : 0;
                default: perm = (k < n_len && k < 1024) ? perm_order[k] : $urandom_range(1023);
            endcase
            send_beat(1'b0, soft_value(), soft_value(), soft_value(), soft_value(), perm);
        end
        for (int k = 0; k < 3; k++) begin
            send_beat(1'b1, soft_value(), soft_value(), soft_value(), soft_value(), 0);
        end
    endtask

    task automatic set_block(int unsigned len, int unsigned iters);
        drain();
        write_reg(CFG_BLOCK_LENGTH, len);
        @(posedge i_clk);
        write_reg(CFG_ITERATION_COUNT, iters);
    endtask

    initial begin
        int unsigned len, iters, n_data, blk;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: field extremes in a four-position block.
        set_block(4, 1);
        send_beat(1'b0, -128, 127, 0, -1, 3);
        send_beat(1'b0, 127, -128, -1, 0, 1023);
        send_beat(1'b0, 1, -1, -128, 127, 0);
        send_beat(1'b0, 0, 0, 127, -128, 2);
        send_beat(1'b1, -128, 127, -128, 127, 0);
        send_beat(1'b1, 127, -128, 127, -128, 1023);
        send_beat(1'b1, 0, 1, -1, 0, 0);
        // Data beyond the block end is ignored.
        set_block(2, 2);
        send_block(4, 2);
        // An early tail decodes with what the stores already hold.
        set_block(4, 3);
        send_block(1, 4);
        // Zero length acts as one and zero iterations as one; all data is then ignored.
        set_block(0, 0);
        send_block(1, 1);
        // Fifteen iterations on a short block.
        set_block(3, 15);
        send_block(3, 3);

        // Random part: mostly short blocks, several phases of idling.
        blk = 0;
        while (items_sent < 470) begin
            set_mode(blk / 2);
            case ($urandom_range(19))
                0: len = 64 + $urandom_range(1);
                1: len = 100 + $urandom_range(60);
                default: len = $urandom_range(1, 30);
            endcase
            iters = ($urandom_range(9) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3);
            n_data = len;
            if ($urandom_range(9) == 0) n_data = len + $urandom_range(1, 3);
            else if ($urandom_range(9) == 0 && sb.high_water >= len)
                n_data = $urandom_range(len);
            set_block(len, iters);
            send_block(n_data, len);
            blk++;
        end

        i_in_valid <= 1'b0;
        while (sb.words_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
